FILE: sv/assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RARE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define RARE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define RARE_ASSERT_SAME(label, clk, rst, ante, cons)
`define RARE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/rare_pkg.sv
`default_nettype none

package rare_pkg;

   localparam int STRENGTH_WIDTH  = 9;
   localparam int TICK_WIDTH      = 12;
   localparam int LEVEL_WIDTH     = 8;
   localparam int PROD_WIDTH      = STRENGTH_WIDTH + TICK_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 12;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANALOG   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRENGTH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATTACK   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE  = 2'd3;

   typedef struct packed {
      logic accept;
      logic mul;
      logic div_step;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: sv/rare_if.sv
`default_nettype none

interface rare_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface rare_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             motor_on;
   logic [rare_pkg::LEVEL_WIDTH-1:0] motor_level;

   modport source (output valid, output motor_on, output motor_level, input ready);
   modport sink (input valid, input motor_on, input motor_level, output ready);
endinterface

`default_nettype wire

FILE: sv/rare_ctrl.sv
`default_nettype none

module rare_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire rare_pkg::ctrl_status_type status,
   output rare_pkg::ctrl_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   localparam int STEP_WIDTH = $clog2(rare_pkg::PROD_WIDTH);
   localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(rare_pkg::PROD_WIDTH - 1);

   logic [1:0]            state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_HOLD;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_HOLD: begin
            // wait until the output register can take the result
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/rare_dp.sv
`default_nettype none

module rare_dp #(
   parameter int COUNTER_WIDTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     csr_we,
   input  wire logic [rare_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [rare_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata,
   input  wire logic                                     req_restart,
   input  wire rare_pkg::ctrl_cmd_type                   cmd,
   output rare_pkg::ctrl_status_type                     status,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic                                          rsp_motor_on,
   output logic [rare_pkg::LEVEL_WIDTH-1:0]              rsp_motor_level
);

   localparam int TW = rare_pkg::TICK_WIDTH;
   localparam int SW = rare_pkg::STRENGTH_WIDTH;
   localparam int PW = rare_pkg::PROD_WIDTH;
   localparam int LW = rare_pkg::LEVEL_WIDTH;

   // configuration
   logic                 analog_ff;
   logic signed [SW-1:0] strength_ff;
   logic [TW-1:0]        attack_ff;
   logic [TW-1:0]        release_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         analog_ff   <= 1'b0;
         strength_ff <= '0;
         attack_ff   <= '0;
         release_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rare_pkg::CSR_ANALOG:   analog_ff   <= csr_wdata[0];
            rare_pkg::CSR_STRENGTH: strength_ff <= csr_wdata[SW-1:0];
            rare_pkg::CSR_ATTACK:   attack_ff   <= csr_wdata[TW-1:0];
            rare_pkg::CSR_RELEASE:  release_ff  <= csr_wdata[TW-1:0];
            default: ;
         endcase
      end
   end

   // phase decode
   logic [COUNTER_WIDTH-1:0] cnt_ff, cnt_in, cnt_now;
   logic [TW:0]              span;
   logic [TW:0]              remain;
   logic                     in_attack, in_release, active;
   logic [COUNTER_WIDTH:0]   cnt_sum;

   assign cnt_now    = req_restart ? '0 : cnt_ff;
   assign span       = {1'b0, attack_ff} + {1'b0, release_ff};
   assign in_attack  = cnt_now < COUNTER_WIDTH'(attack_ff);
   assign in_release = !in_attack && (cnt_now < COUNTER_WIDTH'(span));
   assign remain     = span - cnt_now[TW:0];
   assign active     = (in_attack || in_release) && analog_ff;
   assign cnt_sum    = {1'b0, cnt_now} + ((in_attack || in_release) ?
                       (COUNTER_WIDTH+1)'(2) : (COUNTER_WIDTH+1)'(1));

   // saturating advance
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.accept) begin
         cnt_in = cnt_sum[COUNTER_WIDTH] ? '1 : cnt_sum[COUNTER_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // operands, sign-magnitude
   logic [SW-1:0] mag_ff;
   logic [TW-1:0] num_ff;
   logic [TW-1:0] divisor_ff;
   logic          neg_ff;
   logic          on_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mag_ff     <= strength_ff[SW-1] ? SW'(-strength_ff) : SW'(strength_ff);
         neg_ff     <= strength_ff[SW-1];
         on_ff      <= analog_ff && in_attack;
         num_ff     <= !active ? '0 : (in_attack ? cnt_now[TW-1:0] : remain[TW-1:0]);
         divisor_ff <= !active ? TW'(1) : (in_attack ? attack_ff : release_ff);
      end
   end

   // shift-subtract divider, one quotient bit per step
   logic [PW-1:0] quo_ff;
   logic [TW-1:0] rem_ff;
   logic [TW:0]   trial;
   logic          fits;

   assign trial = {rem_ff, quo_ff[PW-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         quo_ff <= PW'(mag_ff) * PW'(num_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[PW-2:0], fits};
         rem_ff <= fits ? TW'(trial - {1'b0, divisor_ff}) : trial[TW-1:0];
      end
   end

   // output register
   logic          out_valid_ff, out_valid_in;
   logic          motor_on_ff;
   logic [LW-1:0] level_ff;

   assign out_valid_in    = cmd.load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         motor_on_ff <= on_ff;
         level_ff    <= neg_ff ? LW'(~quo_ff[LW-1:0] + 1'b1) : quo_ff[LW-1:0];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_motor_on    = motor_on_ff;
   assign rsp_motor_level = level_ff;

endmodule

`default_nettype wire

FILE: sv/rumble_attack_release_envelope.sv
// Attack/release envelope for a rumble motor: each accepted request is one frame tick
// and yields one response with the small-motor switch and the large-motor level. A
// request passes through these steps in order: the accepting cycle latches operands and
// advances the envelope counter, then the strength multiply, the shift-subtract divider
// that produces one quotient bit a cycle, and the load of the output register. The load
// waits only while an earlier response still waits to be taken. A new request is
// accepted as soon as the previous one has been loaded, even while its response still
// waits. Configuration is to be written through csr_we/csr_index/csr_wdata only while
// idle; the block itself does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module rumble_attack_release_envelope #(
   parameter int COUNTER_WIDTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   rare_req_if.sink                                  req_if,
   rare_rsp_if.source                                rsp_if,
   input  wire logic                                 csr_we,
   input  wire logic [rare_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [rare_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   rare_pkg::ctrl_cmd_type    cmd;
   rare_pkg::ctrl_status_type status;

   rare_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rare_dp #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_restart     (req_if.restart),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_motor_on    (rsp_if.motor_on),
      .rsp_motor_level (rsp_if.motor_level)
   );

   `RARE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_if.valid && req_if.ready, !req_if.ready)
   `RARE_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load, rsp_if.valid)
   `RARE_ASSERT_NEXT(a_taken_clears, clock, reset, rsp_if.valid && rsp_if.ready && !cmd.load, !rsp_if.valid)
   `RARE_ASSERT_SAME(a_load_only_free, clock, reset, cmd.load, !rsp_if.valid || rsp_if.ready)

endmodule

`default_nettype wire
